// ----- src/cpw_pkg.sv -----
// Shared types, constants and the normalization step for the cocircularity pair weight unit.
// No dependencies.
`timescale 1ns / 1ps
package cpw_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 14;
    localparam int DIR_W      = 16;
    localparam int FIELD_W    = 12;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int ACC_W  = 2 * COORD_BITS + 2 * FRAC_BITS + 6;
    localparam int UM_W   = FRAC_BITS + 1;
    localparam int U_W    = FRAC_BITS + 2;
    localparam int NSTG   = FRAC_BITS + 1;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COCIRC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY = 2'd2;

    localparam int WEIGHT_W = 15;
    localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
    localparam longint unsigned CAP_Q = (ONE_Q < 64'd32767) ? ONE_Q : 64'd32767;
    localparam longint unsigned KEEP_Q = (ONE_Q * 64'd1580030169) >> 32;
    localparam logic [WEIGHT_W-1:0] CAP        = WEIGHT_W'(CAP_Q);
    localparam logic [WEIGHT_W-1:0] KEEP_LEVEL = WEIGHT_W'(KEEP_Q);

    typedef struct packed {
        logic [FIELD_W-1:0]      center_row;
        logic [FIELD_W-1:0]      center_col;
        logic [FIELD_W-1:0]      neighbor_row;
        logic [FIELD_W-1:0]      neighbor_col;
        logic signed [DIR_W-1:0] center_dir_x;
        logic signed [DIR_W-1:0] center_dir_y;
        logic signed [DIR_W-1:0] neighbor_dir_x;
        logic signed [DIR_W-1:0] neighbor_dir_y;
    } pair_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                keep_edge;
    } result_t;

    typedef struct packed {
        logic [SQ_W-1:0]         ax2;
        logic [SQ_W-1:0]         ay2;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [DIR_W-1:0] v1x;
        logic signed [DIR_W-1:0] v1y;
        logic signed [DIR_W-1:0] v2x;
        logic signed [DIR_W-1:0] v2y;
    } front_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] lin;
        logic signed [ACC_W-1:0] rhs;
        logic [UM_W-1:0]         mag;
    } lane_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] d2;
        logic                    zero;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [DIR_W-1:0] v1x;
        logic signed [DIR_W-1:0] v1y;
        logic signed [DIR_W-1:0] v2x;
        logic signed [DIR_W-1:0] v2y;
    } side_t;

    typedef struct packed {
        logic signed [U_W-1:0]   ux;
        logic signed [U_W-1:0]   uy;
        logic signed [DIR_W-1:0] v1x;
        logic signed [DIR_W-1:0] v1y;
        logic signed [DIR_W-1:0] v2x;
        logic signed [DIR_W-1:0] v2y;
    } unit_word_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] cone;
        logic signed [DIR_W-1:0] cocirc;
        logic                    binary;
    } cfg_t;

    // Tries bit k of the magnitude: keeps it if (2m-1)^2 * d2 <= rhs.
    // acc holds (2m-1)^2 * d2, lin holds (2m-1) * d2.
    function automatic lane_t lane_step(lane_t ln, logic signed [ACC_W-1:0] d2, int k);
        lane_t                   res;
        logic signed [ACC_W-1:0] trial;
        logic signed [ACC_W-1:0] lin_t;
        res   = ln;
        trial = ln.acc + (ln.lin <<< (k + 2)) + (d2 <<< (2 * k + 2));
        lin_t = ln.lin + (d2 <<< (k + 1));
        if (trial <= ln.rhs)
        begin
            res.acc    = trial;
            res.lin    = lin_t;
            res.mag[k] = 1'b1;
        end
        return res;
    endfunction

endpackage

// ----- src/cocircularity_pair_weight_unit.sv -----
// Top level of the cocircularity pair weight unit: configuration registers, front, queue, back.
// Depends on cpw_pkg, cpw_front, cpw_queue, cpw_unit, cpw_weight.
`timescale 1ns / 1ps
// One pixel pair word is taken per cycle while busy is low and gives one result word,
// strobed by result_valid. Each pair passes the queue, the normalization pipeline, one
// offset bit per stage, and the six-stage weight pipeline after it. The result side
// cannot stall; the back end drains the queue every cycle. Write configuration only
// while no pair is in flight.
module cocircularity_pair_weight_unit
    import cpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pair_t                pair,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t        cfg_reg;
    front_item_t front_word;
    front_item_t queue_word;
    logic        q_empty;
    logic        q_full;
    logic        unit_valid;
    unit_word_t  unit_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cone   <= '0;
            cfg_reg.cocirc <= DIR_W'(ONE_Q);
            cfg_reg.binary <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONE:   cfg_reg.cone   <= cfg_data;
                REG_COCIRC: cfg_reg.cocirc <= cfg_data;
                REG_BINARY: cfg_reg.binary <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign busy = q_full;

    cpw_front u_front (
        .pair (pair),
        .item (front_word)
    );

    cpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_word (front_word),
        .pop       (!q_empty),
        .empty     (q_empty),
        .full      (q_full),
        .pop_word  (queue_word)
    );

    cpw_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .item      (queue_word),
        .out_valid (unit_valid),
        .out_word  (unit_word)
    );

    cpw_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (unit_valid),
        .in_word   (unit_word),
        .out_valid (result_valid),
        .out_word  (result)
    );

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled up");

    a_weight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.weight <= CAP)
        else $error("weight above cap");

    a_keep_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.keep_edge == (result.weight > KEEP_LEVEL)))
        else $error("keep_edge inconsistent with weight");

endmodule

// ----- src/cpw_front.sv -----
// Front end: takes a pixel pair, forms the offset magnitudes, signs and squares.
// Depends on cpw_pkg.
`timescale 1ns / 1ps
module cpw_front
    import cpw_pkg::*;
(
    input  pair_t       pair,
    output front_item_t item
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      ax;
    logic [COORD_BITS-1:0]      ay;

    always_comb
    begin
        dx = $signed({1'b0, pair.neighbor_col[COORD_BITS-1:0]})
           - $signed({1'b0, pair.center_col[COORD_BITS-1:0]});
        dy = $signed({1'b0, pair.neighbor_row[COORD_BITS-1:0]})
           - $signed({1'b0, pair.center_row[COORD_BITS-1:0]});
        ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        item.ax2   = SQ_W'(ax) * SQ_W'(ax);
        item.ay2   = SQ_W'(ay) * SQ_W'(ay);
        item.neg_x = dx[COORD_BITS];
        item.neg_y = dy[COORD_BITS];
        item.v1x   = pair.center_dir_x;
        item.v1y   = pair.center_dir_y;
        item.v2x   = pair.neighbor_dir_x;
        item.v2y   = pair.neighbor_dir_y;
    end

endmodule

// ----- src/cpw_queue.sv -----
// Two-word queue between the front end and the back end.
// Depends on cpw_pkg.
`timescale 1ns / 1ps
module cpw_queue
    import cpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_word,
    input  logic        pop,
    output logic        empty,
    output logic        full,
    output front_item_t pop_word
);

    front_item_t mem [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_next;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- src/cpw_unit.sv -----
// Offset normalization pipeline: one magnitude bit per stage for both components.
// Depends on cpw_pkg.
`timescale 1ns / 1ps
module cpw_unit
    import cpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  front_item_t item,
    output logic        out_valid,
    output unit_word_t  out_word
);

    logic [NSTG:0] valid_reg;
    lane_t         lx_reg [0:NSTG];
    lane_t         ly_reg [0:NSTG];
    side_t         side_reg [0:NSTG];
    lane_t         lx_next [0:NSTG];
    lane_t         ly_next [0:NSTG];
    side_t         side0_next;

    always_comb
    begin
        side0_next.d2    = ACC_W'(item.ax2) + ACC_W'(item.ay2);
        side0_next.zero  = (item.ax2 == '0) && (item.ay2 == '0);
        side0_next.neg_x = item.neg_x;
        side0_next.neg_y = item.neg_y;
        side0_next.v1x   = item.v1x;
        side0_next.v1y   = item.v1y;
        side0_next.v2x   = item.v2x;
        side0_next.v2y   = item.v2y;
        lx_next[0].acc = side0_next.d2;
        lx_next[0].lin = -side0_next.d2;
        lx_next[0].rhs = ACC_W'(item.ax2) <<< (2 * FRAC_BITS + 2);
        lx_next[0].mag = '0;
        ly_next[0].acc = side0_next.d2;
        ly_next[0].lin = -side0_next.d2;
        ly_next[0].rhs = ACC_W'(item.ay2) <<< (2 * FRAC_BITS + 2);
        ly_next[0].mag = '0;
        for (int s = 1; s <= NSTG; s++)
        begin
            lx_next[s] = lane_step(lx_reg[s-1], side_reg[s-1].d2, NSTG - s);
            ly_next[s] = lane_step(ly_reg[s-1], side_reg[s-1].d2, NSTG - s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NSTG-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        lx_reg[0]   <= lx_next[0];
        ly_reg[0]   <= ly_next[0];
        side_reg[0] <= side0_next;
        for (int s = 1; s <= NSTG; s++)
        begin
            lx_reg[s]   <= lx_next[s];
            ly_reg[s]   <= ly_next[s];
            side_reg[s] <= side_reg[s-1];
        end
    end

    always_comb
    begin
        out_valid = valid_reg[NSTG];
        if (side_reg[NSTG].zero)
        begin
            out_word.ux = '0;
            out_word.uy = '0;
        end
        else
        begin
            out_word.ux = side_reg[NSTG].neg_x ? -U_W'(lx_reg[NSTG].mag) : U_W'(lx_reg[NSTG].mag);
            out_word.uy = side_reg[NSTG].neg_y ? -U_W'(ly_reg[NSTG].mag) : U_W'(ly_reg[NSTG].mag);
        end
        out_word.v1x = side_reg[NSTG].v1x;
        out_word.v1y = side_reg[NSTG].v1y;
        out_word.v2x = side_reg[NSTG].v2x;
        out_word.v2y = side_reg[NSTG].v2y;
    end

endmodule

// ----- src/cpw_weight.sv -----
// Conic test, reflection and weight pipeline.
// Depends on cpw_pkg.
`timescale 1ns / 1ps
module cpw_weight
    import cpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  unit_word_t in_word,
    output logic       out_valid,
    output result_t    out_word
);

    localparam int P_W   = DIR_W + U_W;
    localparam int DOT_W = P_W + 1;
    localparam int CMP_W = DOT_W + FRAC_BITS + 2;
    localparam int DQ_W  = DOT_W - FRAC_BITS + 1;
    localparam int T_W   = DQ_W + U_W + 1;
    localparam int RT_W  = T_W - FRAC_BITS + 1;
    localparam int RX_W  = RT_W + 1;
    localparam int Q_W   = RX_W + DIR_W;
    localparam int C_W   = Q_W + 1;
    localparam int CC_W  = C_W + FRAC_BITS + 2;
    localparam int WR_W  = C_W - FRAC_BITS + 1;
    localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);

    logic [5:0] valid_reg;

    // stage 1
    logic signed [P_W-1:0]   p1_reg, p2_reg;
    logic signed [U_W-1:0]   ux1_reg, uy1_reg;
    logic signed [DIR_W-1:0] v1x1_reg, v1y1_reg, v2x1_reg, v2y1_reg;
    // stage 2
    logic                    pass2_reg;
    logic signed [DQ_W-1:0]  dq2_reg;
    logic signed [U_W-1:0]   ux2_reg, uy2_reg;
    logic signed [DIR_W-1:0] v1x2_reg, v1y2_reg, v2x2_reg, v2y2_reg;
    // stage 3
    logic                    pass3_reg;
    logic signed [T_W-1:0]   t1_reg, t2_reg;
    logic signed [DIR_W-1:0] v1x3_reg, v1y3_reg, v2x3_reg, v2y3_reg;
    // stage 4
    logic                    pass4_reg;
    logic signed [RX_W-1:0]  rx4_reg, ry4_reg;
    logic signed [DIR_W-1:0] v2x4_reg, v2y4_reg;
    // stage 5
    logic                    pass5_reg;
    logic signed [Q_W-1:0]   q1_reg, q2_reg;
    // stage 6
    result_t                 res_reg;

    logic signed [DOT_W-1:0] dot;
    logic [DOT_W-1:0]        dot_mag;
    logic [DOT_W:0]          dot_rnd;
    logic [DQ_W-1:0]         dq_mag;
    logic                    pass_next;
    logic signed [DQ_W-1:0]  dq_next;
    logic [T_W-1:0]          t1_mag, t2_mag;
    logic [T_W:0]            t1_rnd, t2_rnd;
    logic signed [RT_W-1:0]  r1, r2;
    logic signed [C_W-1:0]   c_sum;
    logic [C_W-1:0]          c_mag;
    logic [C_W:0]            c_rnd;
    logic [WR_W-1:0]         w_full;
    logic [WR_W-1:0]         w_sat;
    result_t                 res_next;

    always_comb
    begin
        dot       = DOT_W'(p1_reg) + DOT_W'(p2_reg);
        dot_mag   = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
        pass_next = $signed(CMP_W'({1'b0, dot_mag})) >= (CMP_W'(cfg.cone) <<< FRAC_BITS);
        dot_rnd   = (DOT_W + 1)'(dot_mag) + (DOT_W + 1)'(HALF);
        dq_mag    = DQ_W'(dot_rnd >> FRAC_BITS);
        dq_next   = dot[DOT_W-1] ? -$signed(dq_mag) : $signed(dq_mag);

        t1_mag = t1_reg[T_W-1] ? T_W'(-t1_reg) : T_W'(t1_reg);
        t2_mag = t2_reg[T_W-1] ? T_W'(-t2_reg) : T_W'(t2_reg);
        t1_rnd = (T_W + 1)'(t1_mag) + (T_W + 1)'(HALF);
        t2_rnd = (T_W + 1)'(t2_mag) + (T_W + 1)'(HALF);
        r1     = t1_reg[T_W-1] ? -$signed(RT_W'(t1_rnd >> FRAC_BITS))
                               : $signed(RT_W'(t1_rnd >> FRAC_BITS));
        r2     = t2_reg[T_W-1] ? -$signed(RT_W'(t2_rnd >> FRAC_BITS))
                               : $signed(RT_W'(t2_rnd >> FRAC_BITS));

        c_sum  = C_W'(q1_reg) + C_W'(q2_reg);
        c_mag  = c_sum[C_W-1] ? C_W'(-c_sum) : C_W'(c_sum);
        c_rnd  = (C_W + 1)'(c_mag) + (C_W + 1)'(HALF);
        if (!pass5_reg)
        begin
            w_full = '0;
        end
        else if (cfg.binary)
        begin
            w_full = ($signed(CC_W'({1'b0, c_mag})) >= (CC_W'(cfg.cocirc) <<< FRAC_BITS))
                   ? WR_W'(ONE_Q) : '0;
        end
        else
        begin
            w_full = WR_W'(c_rnd >> FRAC_BITS);
        end
        w_sat = (w_full > WR_W'(CAP)) ? WR_W'(CAP) : w_full;
        res_next.weight    = WEIGHT_W'(w_sat);
        res_next.keep_edge = (w_sat > WR_W'(KEEP_LEVEL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= P_W'(in_word.v1x) * P_W'(in_word.ux);
        p2_reg   <= P_W'(in_word.v1y) * P_W'(in_word.uy);
        ux1_reg  <= in_word.ux;
        uy1_reg  <= in_word.uy;
        v1x1_reg <= in_word.v1x;
        v1y1_reg <= in_word.v1y;
        v2x1_reg <= in_word.v2x;
        v2y1_reg <= in_word.v2y;

        pass2_reg <= pass_next;
        dq2_reg   <= dq_next;
        ux2_reg   <= ux1_reg;
        uy2_reg   <= uy1_reg;
        v1x2_reg  <= v1x1_reg;
        v1y2_reg  <= v1y1_reg;
        v2x2_reg  <= v2x1_reg;
        v2y2_reg  <= v2y1_reg;

        pass3_reg <= pass2_reg;
        t1_reg    <= (T_W'(dq2_reg) * T_W'(ux2_reg)) <<< 1;
        t2_reg    <= (T_W'(dq2_reg) * T_W'(uy2_reg)) <<< 1;
        v1x3_reg  <= v1x2_reg;
        v1y3_reg  <= v1y2_reg;
        v2x3_reg  <= v2x2_reg;
        v2y3_reg  <= v2y2_reg;

        pass4_reg <= pass3_reg;
        rx4_reg   <= RX_W'(r1) - RX_W'(v1x3_reg);
        ry4_reg   <= RX_W'(r2) - RX_W'(v1y3_reg);
        v2x4_reg  <= v2x3_reg;
        v2y4_reg  <= v2y3_reg;

        pass5_reg <= pass4_reg;
        q1_reg    <= Q_W'(rx4_reg) * Q_W'(v2x4_reg);
        q2_reg    <= Q_W'(ry4_reg) * Q_W'(v2y4_reg);

        res_reg   <= res_next;
    end

    assign out_valid = valid_reg[5];
    assign out_word  = res_reg;

endmodule

// ----- tb/tb_pair_weight_checker.sv -----
// Checker for the cocircularity pair weight unit: predicts each result word and compares.
// Depends on cpw_pkg.
`timescale 1ns / 1ps
module tb_pair_weight_checker
    import cpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  pair_t                pair,
    input  logic                 result_valid,
    input  result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    logic signed [15:0] cone_thr;
    logic signed [15:0] cocirc_thr;
    logic               binary_on;
    result_t            weight_q[$];

    function automatic longint round_frac(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return v < 0 ? -m : m;
    endfunction

    // Largest m in [0, 2^F] with (2m-1)^2 * d2 <= a^2 * 2^(2F+2).
    function automatic longint unit_component(longint a, longint d2);
        longint lo;
        longint hi;
        longint mid;
        longint t;
        logic [127:0] lhs;
        logic [127:0] rhs;
        lo  = 0;
        hi  = 64'sd1 <<< FRAC_BITS;
        rhs = 128'(a * a) << (2 * FRAC_BITS + 2);
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(d2);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic result_t predict_weight(pair_t p);
        result_t r;
        longint  dx;
        longint  dy;
        longint  d2;
        longint  ux;
        longint  uy;
        longint  dot;
        longint  dq;
        longint  rx;
        longint  ry;
        longint  c;
        longint  w;
        longint  one;
        one = 64'sd1 <<< FRAC_BITS;
        dx  = longint'(p.neighbor_col) - longint'(p.center_col);
        dy  = longint'(p.neighbor_row) - longint'(p.center_row);
        d2  = dx * dx + dy * dy;
        ux  = 0;
        uy  = 0;
        w   = 0;
        if (d2 != 0)
        begin
            ux = unit_component(dx < 0 ? -dx : dx, d2);
            uy = unit_component(dy < 0 ? -dy : dy, d2);
            if (dx < 0)
                ux = -ux;
            if (dy < 0)
                uy = -uy;
        end
        dot = longint'(p.center_dir_x) * ux + longint'(p.center_dir_y) * uy;
        if ((dot < 0 ? -dot : dot) >= longint'(cone_thr) * one)
        begin
            dq = round_frac(dot);
            rx = round_frac(2 * dq * ux) - longint'(p.center_dir_x);
            ry = round_frac(2 * dq * uy) - longint'(p.center_dir_y);
            c  = rx * longint'(p.neighbor_dir_x) + ry * longint'(p.neighbor_dir_y);
            c  = c < 0 ? -c : c;
            if (binary_on)
                w = (c >= longint'(cocirc_thr) * one) ? one : 0;
            else
                w = round_frac(c);
        end
        if (w > longint'(CAP_Q))
            w = longint'(CAP_Q);
        r.weight    = WEIGHT_W'(w);
        r.keep_edge = w > longint'(KEEP_Q);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("checker: mismatch at %0t: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    assign pending = weight_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            cone_thr     <= 16'sd0;
            cocirc_thr   <= 16'sd16384;
            binary_on    <= 1'b0;
            fail_count   = 0;
            results_seen = 0;
            weight_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                results_seen = results_seen + 1;
                if (weight_q.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    exp_r = weight_q.pop_front();
                    if (result.weight !== exp_r.weight)
                        report_mismatch($sformatf("weight %0d, expected %0d",
                                                  result.weight, exp_r.weight));
                    if (result.keep_edge !== exp_r.keep_edge)
                        report_mismatch($sformatf("keep_edge %0b, expected %0b",
                                                  result.keep_edge, exp_r.keep_edge));
                end
            end
            if (start && !busy)
                weight_q.push_back(predict_weight(pair));
            if (cfg_we)
            begin
                if (cfg_index == REG_CONE)
                    cone_thr <= cfg_data;
                else if (cfg_index == REG_COCIRC)
                    cocirc_thr <= cfg_data;
                else if (cfg_index == REG_BINARY)
                    binary_on <= cfg_data[0];
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the cocircularity pair weight unit: stimulus, watchdog and verdict.
// Depends on cpw_pkg, cocircularity_pair_weight_unit, tb_pair_weight_checker.
`timescale 1ns / 1ps
module tb_top
    import cpw_pkg::*;
();

    localparam int LATENCY    = FRAC_BITS + 9;
    localparam int STALL_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pair_t                pair;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   results_seen;
    int                   idle_cycles;
    int                   pairs_sent;
    int                   idle_pct;

    cocircularity_pair_weight_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pair         (pair),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tb_pair_weight_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pair         (pair),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rand_dir();
        int unsigned sel;
        int          ang;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return 16'($urandom);
        if (sel < 4)
            return 16'($urandom_range(0, 32768) - 16384);
        ang = $urandom_range(0, 3);
        return ang == 0 ? 16'sd16384 : ang == 1 ? -16'sd16384 : 16'sd0;
    endfunction

    function automatic logic [11:0] near_coord(logic [11:0] c);
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom);
        return c + 12'($urandom_range(0, 10)) - 12'd5;
    endfunction

    // Unit-ish direction pair: (cos, sin) from a small table of angles.
    task automatic rand_unit(output logic [15:0] x, output logic [15:0] y);
        int unsigned k;
        logic signed [15:0] cs[8];
        cs = '{16'sd16384, 16'sd15137, 16'sd11585, 16'sd6270, 16'sd0,
               -16'sd6270, -16'sd11585, -16'sd15137};
        k = $urandom_range(0, 15);
        x = cs[k % 8];
        y = (k < 8) ? cs[(k + 4) % 8] : -cs[(k + 4) % 8];
    endtask

    task automatic send_pair(pair_t p);
        pairs_sent = pairs_sent + 1;
        start <= 1'b1;
        pair  <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_pair();
        pair_t p;
        logic [15:0] x;
        logic [15:0] y;
        p.center_row = 12'($urandom);
        p.center_col = 12'($urandom);
        p.neighbor_row = near_coord(p.center_row);
        p.neighbor_col = near_coord(p.center_col);
        if ($urandom_range(0, 3) == 0)
        begin
            p.center_dir_x = rand_dir();
            p.center_dir_y = rand_dir();
            p.neighbor_dir_x = rand_dir();
            p.neighbor_dir_y = rand_dir();
        end
        else
        begin
            rand_unit(x, y);
            p.center_dir_x = x;
            p.center_dir_y = y;
            rand_unit(x, y);
            p.neighbor_dir_x = x;
            p.neighbor_dir_y = y;
        end
        if ($urandom_range(0, 31) == 0)
        begin
            p.neighbor_row = p.center_row;
            p.neighbor_col = p.center_col;
        end
        send_pair(p);
    endtask

    function automatic pair_t mk(logic [11:0] cr, logic [11:0] cc, logic [11:0] nr,
                                 logic [11:0] nc, logic [15:0] ax, logic [15:0] ay,
                                 logic [15:0] bx, logic [15:0] by);
        pair_t p;
        p.center_row = cr;
        p.center_col = cc;
        p.neighbor_row = nr;
        p.neighbor_col = nc;
        p.center_dir_x = ax;
        p.center_dir_y = ay;
        p.neighbor_dir_x = bx;
        p.neighbor_dir_y = by;
        return p;
    endfunction

    initial
    begin
        int phase;
        logic [15:0] cone_set[6];
        logic [15:0] cocirc_set[6];
        rst_n       = 1'b0;
        start       = 1'b0;
        pair        = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pairs_sent  = 0;
        idle_pct    = 36;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, extremes, zero offset, non-unit saturation
        send_pair(mk(12'd0, 12'd0, 12'd0, 12'd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        send_pair(mk(12'd0, 12'd0, 12'd4095, 12'd4095, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd16384));
        send_pair(mk(12'd4095, 12'd4095, 12'd0, 12'd0, -16'sd16384, -16'sd16384,
                     -16'sd16384, 16'sd16384));
        send_pair(mk(12'd10, 12'd10, 12'd10, 12'd11, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        send_pair(mk(12'd10, 12'd10, 12'd11, 12'd10, 16'sd11585, 16'sd11585,
                     16'sd11585, -16'sd11585));
        send_pair(mk(12'd100, 12'd100, 12'd103, 12'd104, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 16'h7FFF));
        send_pair(mk(12'd100, 12'd100, 12'd97, 12'd96, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000));
        send_pair(mk(12'd5, 12'd5, 12'd5, 12'd9, 16'sd6270, 16'sd15137, 16'sd6000, 16'sd0));
        drain();
        write_reg(REG_CONE, 16'sd16384);
        write_reg(REG_BINARY, 16'd1);
        write_reg(REG_COCIRC, -16'sd16384);
        @(posedge clk);
        send_pair(mk(12'd0, 12'd0, 12'd0, 12'd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        send_pair(mk(12'd0, 12'd0, 12'd0, 12'd7, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        send_pair(mk(12'd0, 12'd0, 12'd3, 12'd3, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384));
        drain();
        write_reg(REG_CONE, -16'sd16384);
        write_reg(2'd3, 16'hFFFF);
        @(posedge clk);
        send_pair(mk(12'd0, 12'd0, 12'd0, 12'd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        send_pair(mk(12'd1, 12'd2, 12'd4, 12'd6, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        drain();

        cone_set   = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd11585, 16'h7FFF, 16'h8000};
        cocirc_set = '{16'sd16384, -16'sd16384, 16'sd15000, 16'sd0, 16'h7FFF, 16'h8000};
        for (phase = 0; phase < 13; phase++)
        begin
            write_reg(REG_CONE, phase < 6 ? cone_set[phase] : 16'($urandom));
            write_reg(REG_COCIRC, phase < 6 ? cocirc_set[phase] : 16'($urandom));
            write_reg(REG_BINARY, 16'(phase % 2) | 16'($urandom) & 16'hFFFE);
            @(posedge clk);
            idle_pct = (phase == 3) ? 0 : 36;
            repeat (100)
                random_pair();
            drain();
        end

        $display("summary: %0d pairs sent, %0d result words checked over 16 settings",
                 pairs_sent, results_seen);
        $display("summary: cone/cocirc thresholds at extremes, both weight modes");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cpw_pkg.sv
src/cpw_front.sv
src/cpw_queue.sv
src/cpw_unit.sv
src/cpw_weight.sv
src/cocircularity_pair_weight_unit.sv
tb/tb_pair_weight_checker.sv
tb/tb_top.sv
